/* design/tle_pkg.sv */
// shared constants and types for the telnet receive line editor
// telnet command codes, console control characters, event codes, queue entry
// no dependencies
package tle_pkg;

  // default line buffer size in bytes
  localparam int unsigned LINE_BYTES_DEF = 128;

  // width of the reported position field
  localparam int unsigned POS_W = 7;

  // telnet command bytes
  localparam logic [7:0] TN_SE   = 8'd240;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_IAC  = 8'd255;

  // console characters
  localparam logic [7:0] CH_NUL      = 8'd0;
  localparam logic [7:0] CH_ETX      = 8'd3;
  localparam logic [7:0] CH_EOT      = 8'd4;
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_NAK      = 8'd21;
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_UPPER_O  = 8'h4F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_B  = 8'h42;
  localparam logic [7:0] CH_PARAM_LO = 8'h30;
  localparam logic [7:0] CH_PARAM_HI = 8'h3F;

  // editor events
  typedef enum logic [2:0] {
    EV_APPEND    = 3'd0,
    EV_BACKSPACE = 3'd1,
    EV_ENTER     = 3'd2,
    EV_CANCEL    = 3'd3,
    EV_ERASE     = 3'd4,
    EV_RECALL    = 3'd5,
    EV_QUIT      = 3'd6
  } event_e;

  // entry passed from the filter to the editor
  typedef struct packed {
    logic       session;  // new session marker, data ignored
    logic [7:0] data;     // byte that survived the filter
  } q_item_t;

  // queue handshake toward the editor
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

/* design/tle_iac_filter.sv */
// front end: telnet iac command filter
// forwards surviving bytes and session markers into the queue
// depends on tle_pkg
module tle_iac_filter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_cmd_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_telnet_i,
  output logic             in_ready_o,
  input  logic             full_i,
  output logic             push_o,
  output tle_pkg::q_item_t push_item_o
);
  import tle_pkg::*;

  localparam logic [2:0] ST_DATA    = 3'd0;
  localparam logic [2:0] ST_IAC     = 3'd1;
  localparam logic [2:0] ST_OPT     = 3'd2;
  localparam logic [2:0] ST_SUB     = 3'd3;
  localparam logic [2:0] ST_SUB_IAC = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;
  logic       fwd;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    state_d = state_q;
    fwd     = 1'b0;
    if (in_cmd_i) begin
      state_d = ST_DATA;
      fwd     = 1'b1;
    end else if (!in_telnet_i) begin
      fwd = 1'b1;
    end else begin
      case (state_q)
        ST_IAC: begin
          if (in_byte_i == TN_IAC) begin
            state_d = ST_DATA;
            fwd     = 1'b1;
          end else if (in_byte_i >= TN_WILL && in_byte_i <= TN_DONT) begin
            state_d = ST_OPT;
          end else if (in_byte_i == TN_SB) begin
            state_d = ST_SUB;
          end else begin
            state_d = ST_DATA;
          end
        end
        ST_OPT: begin
          state_d = ST_DATA;
        end
        ST_SUB: begin
          if (in_byte_i == TN_IAC) state_d = ST_SUB_IAC;
        end
        ST_SUB_IAC: begin
          state_d = (in_byte_i == TN_SE) ? ST_DATA : ST_SUB;
        end
        default: begin
          // data state, and the unused codes behave the same
          if (in_byte_i == TN_IAC) begin
            state_d = ST_IAC;
          end else begin
            state_d = ST_DATA;
            fwd     = 1'b1;
          end
        end
      endcase
    end
  end

  assign push_o              = accept && fwd;
  assign push_item_o.session = in_cmd_i;
  assign push_item_o.data    = in_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DATA;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

endmodule

/* design/tle_queue.sv */
// two-entry queue between the filter and the editor
// head entry is read directly, ready depends only on the fill level
// depends on tle_pkg
module tle_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tle_pkg::q_item_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output tle_pkg::q_head_t head_o
);
  import tle_pkg::*;

  logic [1:0] count_q, count_d;
  q_item_t    head_q, head_d;
  q_item_t    tail_q, tail_d;

  assign full_o       = (count_q == 2'd2);
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = head_q;

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    if (push_i && pop_i) begin
      if (count_q == 2'd1) begin
        head_d = push_item_i;
      end else begin
        head_d = tail_q;
        tail_d = push_item_i;
      end
    end else if (push_i) begin
      count_d = count_q + 2'd1;
      if (count_q == 2'd0) head_d = push_item_i;
      else                 tail_d = push_item_i;
    end else if (pop_i) begin
      count_d = count_q - 2'd1;
      head_d  = tail_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue fill level out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("pop from empty queue");

endmodule

/* design/tle_editor.sv */
// back end: line editor with registered result stage
// tracks line and history lengths, cr and escape state, emits edit events
// depends on tle_pkg
module tle_editor #(
  parameter int unsigned LINE_BYTES = tle_pkg::LINE_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tle_pkg::q_head_t           head_i,
  output logic                       pop_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output tle_pkg::event_e            res_event_o,
  output logic [7:0]                 res_byte_o,
  output logic [tle_pkg::POS_W-1:0]  res_pos_o
);
  import tle_pkg::*;

  localparam int unsigned LEN_W = $clog2(LINE_BYTES);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BYTES - 1);

  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_START = 2'd1;
  localparam logic [1:0] ESC_SEQ   = 2'd2;

  logic             cr_q, cr_d;
  logic [1:0]       esc_q, esc_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] hist_q, hist_d;

  logic             vld_q;
  event_e           ev_q;
  logic [7:0]       byte_q;
  logic [POS_W-1:0] pos_q;

  logic             emit;
  event_e           ev_d;
  logic [7:0]       byte_d;
  logic [LEN_W-1:0] pos_len;
  logic [7:0]       c;
  logic             slot_free;

  assign c         = head_i.item.data;
  assign slot_free = !vld_q || res_ready_i;
  assign pop_o     = head_i.valid && slot_free;

  always_comb begin
    cr_d    = cr_q;
    esc_d   = esc_q;
    len_d   = len_q;
    hist_d  = hist_q;
    emit    = 1'b0;
    ev_d    = EV_APPEND;
    byte_d  = 8'd0;
    pos_len = '0;
    if (head_i.item.session) begin
      len_d = '0;
    end else begin
      cr_d = (c == CH_CR);
      if (cr_q && (c == CH_LF || c == CH_NUL)) begin
        // line ending pair, second byte swallowed
      end else if (esc_q == ESC_START) begin
        esc_d = (c == CH_LBRACKET || c == CH_UPPER_O) ? ESC_SEQ : ESC_NONE;
      end else if (esc_q != ESC_NONE) begin
        if (c < CH_PARAM_LO || c > CH_PARAM_HI) begin
          esc_d = ESC_NONE;
          if (c == CH_UPPER_A) begin
            len_d   = hist_q;
            emit    = 1'b1;
            ev_d    = EV_RECALL;
            pos_len = hist_q;
          end else if (c == CH_UPPER_B) begin
            len_d   = '0;
            emit    = 1'b1;
            ev_d    = EV_ERASE;
            pos_len = len_q;
          end
        end
      end else if (c == CH_ESC) begin
        esc_d = ESC_START;
      end else if (c == CH_LF || c == CH_CR) begin
        emit    = 1'b1;
        ev_d    = EV_ENTER;
        pos_len = len_q;
        if (len_q != '0) begin
          hist_d = len_q;
          len_d  = '0;
        end
      end else if (c == CH_BS || c == CH_DEL) begin
        if (len_q != '0) begin
          len_d   = len_q - 1'b1;
          emit    = 1'b1;
          ev_d    = EV_BACKSPACE;
          pos_len = len_q - 1'b1;
        end
      end else if (c == CH_ETX) begin
        len_d = '0;
        emit  = 1'b1;
        ev_d  = EV_CANCEL;
      end else if (c == CH_NAK) begin
        len_d   = '0;
        emit    = 1'b1;
        ev_d    = EV_ERASE;
        pos_len = len_q;
      end else if (c == CH_EOT) begin
        if (len_q == '0) begin
          emit = 1'b1;
          ev_d = EV_QUIT;
        end
      end else if (c >= CH_SPACE && len_q < LEN_LIMIT) begin
        len_d   = len_q + 1'b1;
        emit    = 1'b1;
        ev_d    = EV_APPEND;
        byte_d  = c;
        pos_len = len_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q   <= 1'b0;
      esc_q  <= ESC_NONE;
      len_q  <= '0;
      hist_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        cr_q   <= cr_d;
        esc_q  <= esc_d;
        len_q  <= len_d;
        hist_q <= hist_d;
      end
      if (slot_free) vld_q <= pop_o && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      ev_q   <= ev_d;
      byte_q <= byte_d;
      pos_q  <= POS_W'(pos_len);
    end
  end

  assign res_valid_o = vld_q;
  assign res_event_o = ev_q;
  assign res_byte_o  = byte_q;
  assign res_pos_o   = pos_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_LIMIT && hist_q <= LEN_LIMIT)
    else $error("line length beyond buffer");

  a_byte_only_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && ev_q != EV_APPEND |-> byte_q == 8'd0)
    else $error("non-append event carries a byte");

  a_esc_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q != 2'd3)
    else $error("escape tracker in unused code");

endmodule

/* design/telnet_rx_line_editor.sv */
// top level of the telnet receive line editor
// instantiates tle_iac_filter, tle_queue and tle_editor; depends on tle_pkg
//
// usage
//   slave stream: one beat per received console byte or session command.
//     tdata carries the byte, tuser[0] = cmd (1 opens a new session and
//     clears the line), tuser[1] = from_telnet (byte passes the iac filter).
//   master stream: one beat per editor event. tuser carries the event code,
//     tdata[7:0] the appended byte (zero otherwise), tdata[14:8] the position.
//   beats that are filtered or dropped produce no output beat.
// throughput: one input beat per cycle, sustained while the output is taken.
// path: an accepted input beat is stored in the queue register, and its event
//   is then held in the editor result register, which drives the master side.
// reset: telnet filter back to the data state, line and history lengths,
//   cr and escape tracking cleared, queue and output empty.
// stall: the result register holds its beat; the editor stops popping, the
//   two-entry queue fills and then s_axis_tready drops.
module telnet_rx_line_editor #(
  parameter int unsigned LINE_BYTES = tle_pkg::LINE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic [1:0]  s_axis_tuser,   // cmd, from_telnet
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_byte, position, zero pad
  output logic [2:0]  m_axis_tuser    // event_res
);
  import tle_pkg::*;

  logic             q_full;
  logic             q_push;
  q_item_t          q_item;
  logic             q_pop;
  q_head_t          q_head;
  event_e           res_event;
  logic [7:0]       res_byte;
  logic [POS_W-1:0] res_pos;

  // front end: telnet command filter
  tle_iac_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser[0]),
    .in_byte_i   (s_axis_tdata),
    .in_telnet_i (s_axis_tuser[1]),
    .in_ready_o  (s_axis_tready),
    .full_i      (q_full),
    .push_o      (q_push),
    .push_item_o (q_item)
  );

  // decoupling queue
  tle_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head)
  );

  // back end: line editor and result register
  tle_editor #(
    .LINE_BYTES (LINE_BYTES)
  ) u_editor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_event_o (res_event),
    .res_byte_o  (res_byte),
    .res_pos_o   (res_pos)
  );

  assign m_axis_tdata = {1'b0, res_pos, res_byte};
  assign m_axis_tuser = res_event;

endmodule
